// ===== design/brbpc_pkg.sv =====
// brbpc_pkg: shared types and codes for the byte ring buffer with peek and consume
// field widths, operation and result codes, sequencer states
// no dependencies
`default_nettype none

package brbpc_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned AmtW  = 13;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 13;
  localparam int unsigned KindW = 2;

  // input operation codes
  localparam logic [OpW-1:0] OP_WRITE   = 2'd0;
  localparam logic [OpW-1:0] OP_PEEK    = 2'd1;
  localparam logic [OpW-1:0] OP_CONSUME = 2'd2;

  // result kinds
  localparam logic [KindW-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KindW-1:0] KIND_PEEK    = 2'd1;
  localparam logic [KindW-1:0] KIND_CONSUME = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_PEEK_RD,
    ST_PEEK_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== design/byte_ring_buffer_peek_consume.sv =====
// byte_ring_buffer_peek_consume: ring buffer of bytes with chunked write, peek and consume
// one module: sequencer, shared modular head adder, byte memory, output register
// depends on brbpc_pkg
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one word per operation:
// a write byte of a chunk (the first flagged by chunk_start_i with the chunk length in
// amount_i), a peek request or a consume request. The output channel (out_valid_o /
// out_stall_i) returns result words from a single output register. The capacity
// register is written over cfg_valid_i / cfg_ready_o, only while the block is idle;
// a write empties the buffer.
// Timing: the block takes one input word at a time. A write byte passes through EXEC,
// and the byte that closes a chunk also through EMIT; consume passes EXEC and EMIT; a
// peek runs EXEC, then PEEK_RD and PEEK_OUT per byte, the registered memory read in
// PEEK_RD preceding each byte's output, and a peek with nothing to return runs EXEC and EMIT.
// Head advances all go through one shared add-and-wrap unit.
// Reset empties the buffer and sets the capacity to the memory depth, capped at 8191; the
// memory itself is not cleared. While the receiver stalls, the result word is held and
// the sequencer waits, so the input stays stalled.
`default_nettype none

module byte_ring_buffer_peek_consume
  import brbpc_pkg::*;
#(
  parameter int unsigned DEPTH    = 4096,
  parameter int unsigned MAX_PEEK = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CntW-1:0]  cfg_data_i,
  // input words
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [OpW-1:0]   opcode_i,
  input  wire logic [AmtW-1:0]  amount_i,
  input  wire logic             chunk_start_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  // result words
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [KindW-1:0]      kind_o,
  output logic [ByteW-1:0]      data_byte_res_o,
  output logic [CntW-1:0]       count_o,
  output logic                  last_o,
  output logic [CntW-1:0]       used_after_o
);

  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned PW     = $clog2(MAX_PEEK + 1);
  localparam int unsigned SumW   = CntW + 1;
  localparam int unsigned CapLim = (DEPTH > 8191) ? 8191 : DEPTH;
  localparam logic [CntW-1:0] CapMax  = CntW'(CapLim);
  localparam logic [AmtW-1:0] PeekMax = AmtW'(MAX_PEEK);

  state_e state_q, state_d;

  // latched input word
  logic [OpW-1:0]   op_q;
  logic [AmtW-1:0]  amt_q;
  logic             start_q;
  logic [ByteW-1:0] byte_q;

  // buffer state
  logic [CntW-1:0]  cap_q;
  logic [AW-1:0]    rd_head_q, wr_head_q, pos_q;
  logic [CntW-1:0]  used_q;
  logic [CntW-1:0]  rem_q, len_q;
  logic             acc_q;

  // peek run
  logic [PW-1:0]    peek_n_q, left_q;

  // pending single result
  logic [KindW-1:0] res_kind_q;
  logic [CntW-1:0]  res_count_q;

  // output register
  logic             out_valid_q;
  logic [KindW-1:0] kind_q;
  logic [ByteW-1:0] data_q;
  logic [CntW-1:0]  count_q;
  logic             last_q;
  logic [CntW-1:0]  used_after_q;

  // memory
  logic [ByteW-1:0] store_q [DEPTH];
  logic [ByteW-1:0] rd_data_q;
  logic             mem_we, mem_re;

  logic             in_acc, cfg_acc, slot_free;
  logic [CntW-1:0]  free_space, rem_eff, len_eff, cons_n, cfg_cap;
  logic             acc_eff, empty_chunk;
  logic [AmtW-1:0]  peek_clamp, peek_full;
  logic [CntW-1:0]  unit_b;
  logic [AW-1:0]    unit_a, unit_y;
  logic [SumW-1:0]  unit_sum, unit_cap;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign cfg_acc   = cfg_valid_i && cfg_ready_o;
  assign slot_free = !out_valid_q || !out_stall_i;

  // chunk bookkeeping, sizes and clamps
  always_comb begin
    free_space  = cap_q - used_q;
    rem_eff     = start_q ? amt_q : rem_q;
    len_eff     = start_q ? amt_q : len_q;
    acc_eff     = start_q ? (amt_q <= free_space) : acc_q;
    empty_chunk = start_q && (amt_q == '0);
    peek_clamp  = (amt_q > PeekMax) ? PeekMax : amt_q;
    peek_full   = (peek_clamp > used_q) ? used_q : peek_clamp;
    cons_n      = (amt_q > used_q) ? used_q : amt_q;
    if (cfg_data_i == '0) begin
      cfg_cap = CntW'(1);
    end else if (cfg_data_i > CapMax) begin
      cfg_cap = CapMax;
    end else begin
      cfg_cap = cfg_data_i;
    end
  end

  // shared head adder: (a + b) wrapped at the capacity, a below capacity, b at most capacity
  always_comb begin
    unit_sum = SumW'(unit_a) + SumW'(unit_b);
    unit_cap = SumW'(cap_q);
    if (unit_sum >= unit_cap) begin
      unit_y = AW'(unit_sum - unit_cap);
    end else begin
      unit_y = AW'(unit_sum);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (op_q)
          OP_WRITE: begin
            if (empty_chunk) begin
              state_d = ST_EMIT;
            end else if (rem_eff == CntW'(1)) begin
              state_d = ST_EMIT;
            end else begin
              state_d = ST_IDLE;
            end
          end
          OP_PEEK:    state_d = (peek_full == '0) ? ST_EMIT : ST_PEEK_RD;
          OP_CONSUME: state_d = ST_EMIT;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      ST_PEEK_RD: state_d = ST_PEEK_OUT;
      ST_PEEK_OUT: begin
        if (slot_free) state_d = (left_q == PW'(1)) ? ST_IDLE : ST_PEEK_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs and adder operands
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    cfg_ready_o = (state_q == ST_IDLE);
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    unit_a      = wr_head_q;
    unit_b      = CntW'(1);
    case (state_q)
      ST_EXEC: begin
        if (op_q == OP_WRITE) begin
          mem_we = !empty_chunk && (rem_eff != '0) && acc_eff;
        end else if (op_q == OP_CONSUME) begin
          unit_a = rd_head_q;
          unit_b = cons_n;
        end
      end
      ST_PEEK_RD: begin
        mem_re = 1'b1;
        unit_a = pos_q;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // buffer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CapMax;
      rd_head_q <= '0;
      wr_head_q <= '0;
      used_q    <= '0;
      rem_q     <= '0;
      len_q     <= '0;
      acc_q     <= 1'b0;
    end else if (cfg_acc) begin
      cap_q     <= cfg_cap;
      rd_head_q <= '0;
      wr_head_q <= '0;
      used_q    <= '0;
      rem_q     <= '0;
      len_q     <= '0;
      acc_q     <= 1'b0;
    end else if (state_q == ST_EXEC) begin
      if (op_q == OP_WRITE) begin
        if (start_q) begin
          len_q <= amt_q;
          acc_q <= acc_eff;
        end
        if (empty_chunk) begin
          rem_q <= '0;
        end else if (rem_eff != '0) begin
          rem_q <= rem_eff - CntW'(1);
          if (acc_eff) begin
            wr_head_q <= unit_y;
            used_q    <= used_q + CntW'(1);
          end
        end
      end else if (op_q == OP_CONSUME) begin
        rd_head_q <= unit_y;
        used_q    <= used_q - cons_n;
      end
    end
  end

  // latched word, peek run and pending result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= opcode_i;
      amt_q   <= amount_i;
      start_q <= chunk_start_i;
      byte_q  <= data_byte_i;
    end
    case (state_q)
      ST_EXEC: begin
        peek_n_q <= PW'(peek_full);
        left_q   <= PW'(peek_full);
        pos_q    <= rd_head_q;
        case (op_q)
          OP_WRITE: begin
            res_kind_q  <= KIND_WRITE;
            res_count_q <= (!empty_chunk && acc_eff) ? len_eff : '0;
          end
          OP_PEEK: begin
            res_kind_q  <= KIND_PEEK;
            res_count_q <= '0;
          end
          default: begin
            res_kind_q  <= KIND_CONSUME;
            res_count_q <= cons_n;
          end
        endcase
      end
      ST_PEEK_RD: begin
        pos_q <= unit_y;
      end
      ST_PEEK_OUT: begin
        if (slot_free) left_q <= left_q - PW'(1);
      end
      default: begin
        pos_q <= pos_q;
      end
    endcase
  end

  // byte memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[wr_head_q] <= byte_q;
    if (mem_re) rd_data_q <= store_q[pos_q];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= (state_q == ST_EMIT) || (state_q == ST_PEEK_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (state_q == ST_EMIT) begin
        kind_q       <= res_kind_q;
        data_q       <= '0;
        count_q      <= res_count_q;
        last_q       <= 1'b1;
        used_after_q <= used_q;
      end else if (state_q == ST_PEEK_OUT) begin
        kind_q       <= KIND_PEEK;
        data_q       <= rd_data_q;
        count_q      <= CntW'(peek_n_q);
        last_q       <= (left_q == PW'(1));
        used_after_q <= used_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_byte_res_o = data_q;
  assign count_o         = count_q;
  assign last_o          = last_q;
  assign used_after_o    = used_after_q;

endmodule

`default_nettype wire
